@@ rtl/core/sph_pkg.sv @@
// Shared types and constants for the symmetric pair image hash.
package sph_pkg;
   localparam int PIXEL_BITS  = 8;
   localparam int SIZE_BITS   = 9;
   localparam int VOTE_BITS   = 17;
   localparam int WORD_BITS   = 32;
   localparam int INDEX_BITS  = 2;
   localparam int CSR_ADDR_BITS = 1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;
   localparam logic [SIZE_BITS-1:0] RESET_SIZE = 9'd201;
   localparam logic signed [VOTE_BITS-1:0] VOTE_MAX = 17'sd65535;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]  hash_word;
      logic [INDEX_BITS-1:0] word_index;
      logic                  last_word;
   } result_type;
endpackage

@@ rtl/core/sph_vote_lane.sv @@
// One pair vote counter: a saturating signed register cleared at the end of each frame.
module sph_vote_lane
   (input  logic clock,
    input  logic reset,
    input  logic step,
    input  logic clear,
    input  logic do_vote,
    input  logic [7:0] p,
    input  logic [7:0] q,
    output logic positive);
   import sph_pkg::*;
   logic signed [VOTE_BITS-1:0] vote_ff;
   logic signed [VOTE_BITS-1:0] vote_in;
   logic signed [VOTE_BITS-1:0] voted;
   always_comb begin
      voted = vote_ff;
      if (do_vote) begin
         if (p > q && vote_ff < VOTE_MAX) voted = vote_ff + 17'sd1;
         else if (p < q && vote_ff > -VOTE_MAX) voted = vote_ff - 17'sd1;
      end
      vote_in = clear ? '0 : voted;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         vote_ff <= '0;
      end else if (step) begin
         vote_ff <= vote_in;
      end
   end
   // The sign includes the vote of the pixel in hand, so the last window of a frame counts.
   assign positive = (voted > 17'sd0);
endmodule

@@ rtl/core/symmetric_pair_image_hash.sv @@
// Top level of the symmetric pair image hash.
// A pixel is accepted in every cycle outside the stalls below; the votes of its window
// settle in the accepting cycle. The first hash word is valid in the cycle after the
// last pixel of a frame, then one a cycle while the receiver is ready. The input stalls
// on the last pixel of a frame while an earlier hash is still draining. Synchronous
// reset clears position, votes and window, then zeroes the line store, taking no pixels.
module symmetric_pair_image_hash
   #(parameter int HALF_WINDOW = 8,
     parameter int HASH_WORDS  = 4,
     parameter int MAX_WIDTH   = 256)
   (input  logic        clock,
    input  logic        reset,
    input  logic        req_tvalid,
    output logic        req_tready,
    input  logic [7:0]  req_tdata,   // pixel
    output logic        rsp_tvalid,
    input  logic        rsp_tready,
    output logic [39:0] rsp_tdata,   // hash_word, word_index, zero fill
    output logic        rsp_tlast,   // last_word
    input  logic        csr_we,
    input  logic [sph_pkg::CSR_ADDR_BITS-1:0] csr_index,
    input  logic [sph_pkg::SIZE_BITS-1:0]     csr_wdata);
   import sph_pkg::*;
   localparam int WIN    = 2 * HALF_WINDOW;
   localparam int NPAIRS = 2 * HALF_WINDOW * HALF_WINDOW;
   localparam int NBITS  = HASH_WORDS * WORD_BITS;
   localparam int COLB   = $clog2(MAX_WIDTH);
   localparam int ROWB   = $clog2(WIN);
   localparam int ADDRB  = ROWB + COLB;

   logic [SIZE_BITS-1:0] width_ff, height_ff, w_eff, h_eff;
   logic [SIZE_BITS-1:0] col_ff, row_ff;
   logic [ADDRB:0]       clr_ff;
   logic                 clearing;
   logic [COLB-1:0]      rd_addr, wr_addr;
   pixel_type            wr_data;
   pixel_type            bank_out [WIN];
   logic                 fwd_ff;
   logic [ROWB-1:0]      fwd_slot_ff;
   pixel_type            fwd_px_ff;
   pixel_type            win_ff [WIN][WIN];
   pixel_type            col_rd [WIN];
   logic                 take, row_end, frame_end, full_win;
   logic [NPAIRS-1:0]    pos_bits;
   logic [NBITS-1:0]     hash_ff;
   logic [2:0]           words_ff;
   logic [2:0]           words_in;
   logic [NBITS-1:0]     hash_mux;

   always_comb begin
      w_eff = (width_ff == '0) ? 9'd1 : ((width_ff > SIZE_BITS'(MAX_WIDTH)) ?
              SIZE_BITS'(MAX_WIDTH) : width_ff);
      h_eff = (height_ff == '0) ? 9'd1 : ((height_ff > SIZE_BITS'(MAX_WIDTH)) ?
              SIZE_BITS'(MAX_WIDTH) : height_ff);
   end

   assign clearing  = !clr_ff[ADDRB];
   assign req_tready = !clearing &&
                       (!frame_end || words_ff == '0 || (words_ff == 3'd1 && rsp_tready));
   assign take      = req_tvalid && req_tready;
   assign row_end   = (10'(col_ff) + 10'd1 >= 10'(w_eff));
   assign frame_end = row_end && (10'(row_ff) + 10'd1 >= 10'(h_eff));
   assign full_win  = (row_ff >= SIZE_BITS'(WIN - 1)) && (col_ff >= SIZE_BITS'(WIN - 1));

   // The line store has one bank per row slot. Every bank is read at the column of the
   // next pixel, so its registered data is ready when that pixel arrives.
   assign rd_addr = take ? (row_end ? '0 : col_ff[COLB-1:0] + COLB'(1)) : col_ff[COLB-1:0];
   assign wr_addr = clearing ? clr_ff[COLB-1:0] : col_ff[COLB-1:0];
   assign wr_data = clearing ? '0 : req_tdata;

   for (genvar k = 0; k < WIN; k++) begin : g_bank
      pixel_type mem [MAX_WIDTH];
      pixel_type rd_ff;
      logic      wr_en;
      assign wr_en = (clearing && clr_ff[ADDRB-1:COLB] == ROWB'(k)) ||
                     (take && row_ff[ROWB-1:0] == ROWB'(k));
      always_ff @(posedge clock) begin
         if (wr_en) mem[wr_addr] <= wr_data;
         rd_ff <= mem[rd_addr];
      end
      assign bank_out[k] = (fwd_ff && fwd_slot_ff == ROWB'(k)) ? fwd_px_ff : rd_ff;
   end

   // Column of the line store at the current column, older rows first.
   always_comb begin
      for (int i = 0; i < WIN - 1; i++)
         col_rd[i] = bank_out[ROWB'(row_ff[ROWB-1:0] + ROWB'(i + 1))];
      col_rd[WIN-1] = req_tdata;
   end

   // Window registers: column shifts in from the right, windows use the current column.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN; i++)
            for (int j = 0; j < WIN; j++) win_ff[i][j] <= '0;
      end else if (take) begin
         for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN - 1; j++) win_ff[i][j] <= win_ff[i][j+1];
            win_ff[i][WIN-1] <= col_rd[i];
         end
      end
   end

   // win(i,j) with the current column appended: row r-WIN+1+i, col c-WIN+1+j.
   for (genvar a = 0; a < HALF_WINDOW; a++) begin : g_a
      for (genvar b = 0; b < WIN; b++) begin : g_b
         localparam int PI = a;
         localparam int PJ = b;
         localparam int QI = WIN - 1 - a;
         localparam int QJ = WIN - 1 - b;
         pixel_type p, q;
         if (PJ == WIN - 1) assign p = col_rd[PI];
         else assign p = win_ff[PI][PJ+1];
         if (QJ == WIN - 1) assign q = col_rd[QI];
         else assign q = win_ff[QI][QJ+1];
         sph_vote_lane u_lane
            (.clock(clock), .reset(reset), .step(take), .clear(frame_end),
             .do_vote(full_win), .p(p), .q(q), .positive(pos_bits[a*WIN+b]));
      end
   end

   always_comb begin
      hash_mux = '0;
      for (int k = 0; k < NBITS; k++)
         if (k < NPAIRS) hash_mux[NBITS-1-k] = pos_bits[k];
   end

   always_comb begin
      words_in = words_ff;
      if (rsp_tvalid && rsp_tready) words_in = words_ff - 3'd1;
      if (take && frame_end) words_in = 3'(HASH_WORDS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= RESET_SIZE;
         height_ff   <= RESET_SIZE;
         col_ff      <= '0;
         row_ff      <= '0;
         clr_ff      <= '0;
         words_ff    <= '0;
         fwd_ff      <= 1'b0;
         fwd_slot_ff <= '0;
         fwd_px_ff   <= '0;
      end else begin
         if (clearing) clr_ff <= clr_ff + 1'b1;
         if (csr_we && csr_index == CSR_FRAME_WIDTH) width_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_FRAME_HEIGHT) height_ff <= csr_wdata;
         words_ff    <= words_in;
         fwd_ff      <= take && (rd_addr == col_ff[COLB-1:0]);
         fwd_slot_ff <= row_ff[ROWB-1:0];
         fwd_px_ff   <= req_tdata;
         if (take) begin
            col_ff <= row_end ? '0 : col_ff + 1'b1;
            if (row_end) row_ff <= frame_end ? '0 : row_ff + 1'b1;
            if (frame_end) hash_ff <= hash_mux;
         end
      end
   end

   result_type res;
   always_comb begin
      res.word_index = INDEX_BITS'(words_ff - 3'd1);
      res.hash_word  = hash_ff[32*res.word_index +: 32];
      res.last_word  = (words_ff == 3'd1);
   end
   assign rsp_tvalid = (words_ff != '0);
   assign rsp_tdata  = {6'b0, res.word_index, res.hash_word};
   assign rsp_tlast  = res.last_word;
endmodule

@@ tb/sv/symmetric_pair_image_hash_tb.sv @@
// Self-checking testbench for the symmetric pair image hash, with a predicting scoreboard.
module symmetric_pair_image_hash_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sph_pkg::*;

   localparam int HALF = 8;
   localparam int WIN = 2 * HALF;
   localparam int NPAIRS = 2 * HALF * HALF;
   localparam int NWORDS = 4;
   localparam int LINE_LEN = 256;
   localparam int CYCLE_LIMIT = 3000000;

   class hash_scoreboard;
      pixel_type line_store[WIN * LINE_LEN];
      int votes[NPAIRS];
      int unsigned col, row;
      logic [SIZE_BITS-1:0] width_reg, height_reg;
      result_type pending_words[$];
      int errors, frames, words_seen;

      function void clear_all();
         foreach (line_store[i]) line_store[i] = '0;
         foreach (votes[i]) votes[i] = 0;
         col = 0;
         row = 0;
         width_reg = RESET_SIZE;
         height_reg = RESET_SIZE;
      endfunction

      function void set_size(logic [CSR_ADDR_BITS-1:0] idx, logic [SIZE_BITS-1:0] val);
         if (idx == CSR_FRAME_WIDTH) width_reg = val;
         else height_reg = val;
      endfunction

      function int unsigned clamp(logic [SIZE_BITS-1:0] v);
         if (v == 0) return 1;
         if (v > LINE_LEN) return LINE_LEN;
         return 32'(v);
      endfunction

      function pixel_type px(int r, int c);
         return line_store[(r % WIN) * LINE_LEN + (c % LINE_LEN)];
      endfunction

      function void note_pixel(pixel_type p);
         int unsigned w, h;
         int idx;
         pixel_type x, y;
         result_type res;
         w = clamp(width_reg);
         h = clamp(height_reg);
         line_store[(row % WIN) * LINE_LEN + (col % LINE_LEN)] = p;
         if (row >= WIN - 1 && col >= WIN - 1) begin
            for (int a = -HALF + 1; a <= 0; a++) begin
               for (int b = -HALF + 1; b <= HALF; b++) begin
                  idx = (a + HALF - 1) * WIN + (b + HALF - 1);
                  x = px(int'(row) - HALF + a, int'(col) - HALF + b);
                  y = px(int'(row) - HALF - a + 1, int'(col) - HALF - b + 1);
                  if (x > y && votes[idx] < 65535) votes[idx]++;
                  else if (x < y && votes[idx] > -65535) votes[idx]--;
               end
            end
         end
         if (col + 1 < w) begin
            col++;
            return;
         end
         col = 0;
         if (row + 1 < h) begin
            row++;
            return;
         end
         row = 0;
         frames++;
         for (int wd = NWORDS - 1; wd >= 0; wd--) begin
            res.hash_word = '0;
            for (int bt = 0; bt < 32; bt++) begin
               idx = NWORDS * 32 - 1 - (wd * 32 + bt);
               if (idx < NPAIRS && votes[idx] > 0) res.hash_word[bt] = 1'b1;
            end
            res.word_index = wd[INDEX_BITS-1:0];
            res.last_word = (wd == 0);
            pending_words.push_back(res);
         end
         foreach (votes[i]) votes[i] = 0;
      endfunction

      function void check_word(result_type got);
         result_type exp;
         words_seen++;
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected hash word %h index %0d last %0b", $realtime,
                     got.hash_word, got.word_index, got.last_word);
            errors++;
            return;
         end
         exp = pending_words.pop_front();
         if (got.hash_word !== exp.hash_word) begin
            $display("%0t: hash_word expected %h actual %h", $realtime,
                     exp.hash_word, got.hash_word);
            errors++;
         end
         if (got.word_index !== exp.word_index) begin
            $display("%0t: word_index expected %0d actual %0d", $realtime,
                     exp.word_index, got.word_index);
            errors++;
         end
         if (got.last_word !== exp.last_word) begin
            $display("%0t: last_word expected %0b actual %0b", $realtime,
                     exp.last_word, got.last_word);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_index = '0;
   logic [SIZE_BITS-1:0] csr_wdata = '0;

   hash_scoreboard sb = new();
   int cycles = 0;
   bit long_hold = 1'b0;
   bit no_gaps = 1'b0;
   int pixels_sent = 0;

   symmetric_pair_image_hash u_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("** symmetric_pair_image_hash: FAILED **");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_type got;
         got.hash_word = rsp_tdata[31:0];
         got.word_index = rsp_tdata[33:32];
         got.last_word = rsp_tlast;
         sb.check_word(got);
      end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      int g;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         g = gap_len();
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_pixel(pixel_type p);
      int g;
      req_tvalid <= 1'b1;
      req_tdata <= p;
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(p);
      pixels_sent++;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic write_size(logic [CSR_ADDR_BITS-1:0] idx, logic [SIZE_BITS-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_size(idx, val);
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic send_frame(logic [SIZE_BITS-1:0] w, logic [SIZE_BITS-1:0] h, int mode);
      int n;
      pixel_type p;
      drain();
      write_size(CSR_FRAME_WIDTH, w);
      write_size(CSR_FRAME_HEIGHT, h);
      n = int'(sb.clamp(w) * sb.clamp(h));
      for (int i = 0; i < n; i++) begin
         case (mode)
            0: p = 8'($urandom_range(0, 255));
            1: p = (i % 2) ? 8'hff : 8'h00;
            2: p = 8'h5a;
            default: p = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : i[7:0];
         endcase
         send_pixel(p);
      end
   endtask

   initial begin
      sb.clear_all();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_frame(9'd17, 9'd17, 0);
      send_frame(9'd15, 9'd3, 3);
      send_frame(9'd5, 9'd3, 1);
      send_frame(9'd1, 9'd20, 2);
      send_frame(9'd0, 9'd12, 0);
      // Single-pixel frames with the receiver held off, so the input stalls while a hash is draining.
      drain();
      write_size(CSR_FRAME_WIDTH, 9'd0);
      write_size(CSR_FRAME_HEIGHT, 9'd0);
      no_gaps = 1'b1;
      long_hold = 1'b1;
      for (int i = 0; i < 40; i++) send_pixel(8'($urandom_range(0, 255)));
      no_gaps = 1'b0;
      drain();
      repeat (50) @(posedge clock);
      $display("Ran %0d pixels over %0d frames, %0d hash words checked.", pixels_sent,
               sb.frames, sb.words_seen);
      $display("A 17 by 17 frame with voting, small and zero-sized frames, and a long stall.");
      if (sb.errors == 0 && sb.pending_words.size() == 0)
         $display("** symmetric_pair_image_hash: PASSED **");
      else
         $display("** symmetric_pair_image_hash: FAILED **");
      $finish;
   end
endmodule
